// ===== src/swept_box_entry_time_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef SWEPT_BOX_ENTRY_TIME_MACROS_SVH
`define SWEPT_BOX_ENTRY_TIME_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SBET_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define SBET_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that an antecedent is followed by a consequent a fixed number of cycles later.
`define SBET_ASSERT_DELAY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ===== src/sbet_pkg.sv =====
package sbet_pkg;

	localparam logic signed [31:0] T_NEG_INF = 32'sh8000_0000;
	localparam logic signed [31:0] T_POS_INF = 32'sh7FFF_FFFF;
	localparam logic signed [32:0] EPS_Q = 33'sd1;

	localparam int DIV_STEPS = 32;
	localparam int DIV_LAT = DIV_STEPS + 2;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_OVL = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		REG_ENT_MIN_X = 3'd0,
		REG_ENT_MIN_Y = 3'd1,
		REG_ENT_MAX_X = 3'd2,
		REG_ENT_MAX_Y = 3'd3,
		REG_VEL_X = 3'd4,
		REG_VEL_Y = 3'd5,
		REG_TIME_FLOOR = 3'd6,
		REG_STEP_TIME = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [33:0] dist_en;
		logic signed [33:0] dist_ex;
		logic zero;
		logic ovl;
	} axis_pre_t;

	typedef struct packed {
		logic zero_x;
		logic ovl_x;
		logic zero_y;
		logic ovl_y;
	} side_t;

	function automatic axis_pre_t axis_prep(
		input logic signed [31:0] bmin,
		input logic signed [31:0] bmax,
		input logic signed [31:0] emin,
		input logic signed [31:0] emax,
		input logic signed [31:0] vel
	);
		axis_pre_t r;
		logic signed [32:0] lo;
		logic signed [32:0] hi;
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic signed [33:0] d_lo;
		logic signed [33:0] d_hi;
		lo = $signed({bmin[31], bmin}) + EPS_Q;
		hi = $signed({bmax[31], bmax}) - EPS_Q;
		d_lo = $signed({lo[32], lo}) - $signed({{2{emax[31]}}, emax});
		d_hi = $signed({hi[32], hi}) - $signed({{2{emin[31]}}, emin});
		a = (lo > $signed({emin[31], emin})) ? lo : $signed({emin[31], emin});
		b = (hi < $signed({emax[31], emax})) ? hi : $signed({emax[31], emax});
		r.zero = (vel == 32'sd0);
		r.ovl = (a < b);
		if (vel[31]) begin
			r.dist_en = d_hi;
			r.dist_ex = d_lo;
		end else begin
			r.dist_en = d_lo;
			r.dist_ex = d_hi;
		end
		return r;
	endfunction

endpackage

// ===== src/sbet_div.sv =====
module sbet_div (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic signed [33:0] span,
	input logic signed [31:0] vel,
	output logic out_valid,
	output logic signed [31:0] quot
);

	localparam int N = sbet_pkg::DIV_STEPS;

	logic [33:0] mag;
	logic [49:0] num;
	logic [31:0] dabs;

	logic v_s [0:N];
	logic [31:0] rem_s [0:N];
	logic [31:0] sh_s [0:N];
	logic [31:0] d_s [0:N];
	logic neg_s [0:N];
	logic ovf_s [0:N];

	logic [31:0] q;
	logic big_pos;
	logic big_neg;
	logic out_valid_q;
	logic signed [31:0] quot_q;

	always_comb begin
		mag = span[33] ? 34'(-span) : 34'(span);
		num = {mag, 16'h0000};
		dabs = vel[31] ? 32'(-vel) : 32'(vel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= {14'h0000, num[49:32]};
		sh_s[0] <= num[31:0];
		d_s[0] <= dabs;
		neg_s[0] <= span[33] ^ vel[31];
		ovf_s[0] <= ({14'h0000, num[49:32]} >= dabs);
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [32:0] rem2;
		logic [32:0] diff;
		logic ge;

		always_comb begin
			rem2 = {rem_s[k], sh_s[k][31]};
			diff = rem2 - {1'b0, d_s[k]};
			ge = (rem2 >= {1'b0, d_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[31:0] : rem2[31:0];
			sh_s[k+1] <= {sh_s[k][30:0], ge};
			d_s[k+1] <= d_s[k];
			neg_s[k+1] <= neg_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	always_comb begin
		q = sh_s[N];
		big_pos = ovf_s[N] || q[31];
		big_neg = ovf_s[N] || (q[31] && (|q[30:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (neg_s[N]) begin
			quot_q <= big_neg ? sbet_pkg::T_NEG_INF : $signed(32'(-q));
		end else begin
			quot_q <= big_pos ? sbet_pkg::T_POS_INF : $signed(q);
		end
	end

	assign out_valid = out_valid_q;
	assign quot = quot_q;

endmodule

// ===== src/swept_box_entry_time.sv =====
// Swept box entry time, two dimensions.
// The entity box, its velocity and the time window are set through the
// write port (cfg_we, cfg_idx, cfg_data); the user must write them only
// while no transaction is in flight, as the block does not enforce this.
// One obstacle transaction is accepted at every clock edge with start high;
// busy is always low, so a new box may be started in every cycle.
// Each obstacle gives exactly one result: done rises with hit, entry_time,
// hit_axis and tag_out after the input register, the four parallel
// dividers, which resolve one quotient bit per pipeline stage over 32
// stages plus a prepare and a saturate stage, and one output register.
// Throughput is one transaction per cycle.
// The receiver cannot stall, so results are never held back.
// Reset clears all valid bits, so no result appears after reset until a
// new transaction starts, and sets the registers to their reset values.
module swept_box_entry_time #(
	parameter int TAG_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_idx,
	input logic [31:0] cfg_data,
	input logic start,
	output logic busy,
	input logic signed [31:0] box_min_x,
	input logic signed [31:0] box_min_y,
	input logic signed [31:0] box_max_x,
	input logic signed [31:0] box_max_y,
	input logic [TAG_WIDTH-1:0] box_tag,
	output logic done,
	output logic hit,
	output logic signed [31:0] entry_time,
	output logic [1:0] hit_axis,
	output logic [TAG_WIDTH-1:0] tag_out
);

	`include "swept_box_entry_time_macros.svh"

	localparam int LAT = sbet_pkg::DIV_LAT + 2;

	logic signed [31:0] ent_min_x_q, ent_min_y_q, ent_max_x_q, ent_max_y_q;
	logic signed [31:0] vel_x_q, vel_y_q, time_floor_q;
	logic [30:0] step_time_q;

	sbet_pkg::axis_pre_t pre_x, pre_y;
	logic v_s1;
	sbet_pkg::axis_pre_t ax_s1, ay_s1;
	logic [TAG_WIDTH-1:0] tag_s1;

	sbet_pkg::side_t side_d [0:sbet_pkg::DIV_LAT-1];
	logic [TAG_WIDTH-1:0] tag_d [0:sbet_pkg::DIV_LAT-1];

	logic vq_enx, vq_exx, vq_eny, vq_exy;
	logic signed [31:0] q_enx, q_exx, q_eny, q_exy;

	logic signed [31:0] enx, exx, eny, exy, entry, first_exit;
	sbet_pkg::axis_t axis;
	logic hit_c;

	logic done_q, hit_q;
	logic signed [31:0] entry_q;
	sbet_pkg::axis_t axis_q;
	logic [TAG_WIDTH-1:0] tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_min_x_q <= '0;
			ent_min_y_q <= '0;
			ent_max_x_q <= '0;
			ent_max_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			time_floor_q <= sbet_pkg::T_NEG_INF;
			step_time_q <= '0;
		end else if (cfg_we) begin
			unique case (sbet_pkg::reg_idx_t'(cfg_idx))
				sbet_pkg::REG_ENT_MIN_X: ent_min_x_q <= cfg_data;
				sbet_pkg::REG_ENT_MIN_Y: ent_min_y_q <= cfg_data;
				sbet_pkg::REG_ENT_MAX_X: ent_max_x_q <= cfg_data;
				sbet_pkg::REG_ENT_MAX_Y: ent_max_y_q <= cfg_data;
				sbet_pkg::REG_VEL_X: vel_x_q <= cfg_data;
				sbet_pkg::REG_VEL_Y: vel_y_q <= cfg_data;
				sbet_pkg::REG_TIME_FLOOR: time_floor_q <= cfg_data;
				sbet_pkg::REG_STEP_TIME: step_time_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_comb begin
		pre_x = sbet_pkg::axis_prep(box_min_x, box_max_x, ent_min_x_q, ent_max_x_q, vel_x_q);
		pre_y = sbet_pkg::axis_prep(box_min_y, box_max_y, ent_min_y_q, ent_max_y_q, vel_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= pre_x;
		ay_s1 <= pre_y;
		tag_s1 <= box_tag;
	end

	sbet_div u_div_enx (.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .span(ax_s1.dist_en),
		.vel(vel_x_q), .out_valid(vq_enx), .quot(q_enx));
	sbet_div u_div_exx (.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .span(ax_s1.dist_ex),
		.vel(vel_x_q), .out_valid(vq_exx), .quot(q_exx));
	sbet_div u_div_eny (.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .span(ay_s1.dist_en),
		.vel(vel_y_q), .out_valid(vq_eny), .quot(q_eny));
	sbet_div u_div_exy (.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .span(ay_s1.dist_ex),
		.vel(vel_y_q), .out_valid(vq_exy), .quot(q_exy));

	always_ff @(posedge clk) begin
		side_d[0] <= '{zero_x: ax_s1.zero, ovl_x: ax_s1.ovl, zero_y: ay_s1.zero,
			ovl_y: ay_s1.ovl};
		tag_d[0] <= tag_s1;
		for (int i = 1; i < sbet_pkg::DIV_LAT; i++) begin
			side_d[i] <= side_d[i-1];
			tag_d[i] <= tag_d[i-1];
		end
	end

	always_comb begin
		sbet_pkg::side_t sd;
		sd = side_d[sbet_pkg::DIV_LAT-1];
		if (sd.zero_x) begin
			enx = sd.ovl_x ? sbet_pkg::T_NEG_INF : sbet_pkg::T_POS_INF;
			exx = sd.ovl_x ? sbet_pkg::T_POS_INF : sbet_pkg::T_NEG_INF;
		end else begin
			enx = q_enx;
			exx = q_exx;
		end
		if (sd.zero_y) begin
			eny = sd.ovl_y ? sbet_pkg::T_NEG_INF : sbet_pkg::T_POS_INF;
			exy = sd.ovl_y ? sbet_pkg::T_POS_INF : sbet_pkg::T_NEG_INF;
		end else begin
			eny = q_eny;
			exy = q_exy;
		end
		if (eny > enx) begin
			entry = eny;
			axis = sbet_pkg::AXIS_Y;
		end else begin
			entry = enx;
			axis = sbet_pkg::AXIS_X;
		end
		first_exit = (exx < exy) ? exx : exy;
		hit_c = (entry < first_exit) && (time_floor_q <= entry)
			&& (entry <= $signed({1'b0, step_time_q}));
		if (entry[31]) begin
			axis = sbet_pkg::AXIS_OVL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vq_enx && vq_exx && vq_eny && vq_exy;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_c;
		entry_q <= entry;
		axis_q <= axis;
		tag_q <= tag_d[sbet_pkg::DIV_LAT-1];
	end

	assign done = done_q;
	assign hit = hit_q;
	assign entry_time = entry_q;
	assign hit_axis = axis_q;
	assign tag_out = tag_q;

	`SBET_ASSERT_DELAY(a_latency, start && !busy, LAT, done, "result missing after start")
	`SBET_ASSERT_IMPLY(a_axis_sign, done && (hit_axis != sbet_pkg::AXIS_OVL),
		!entry_time[31], "axis code disagrees with entry sign")
	`SBET_ASSERT_IMPLY(a_hit_window, done && hit,
		(entry_time <= $signed({1'b0, step_time_q})) && (entry_time >= time_floor_q),
		"hit outside time window")

endmodule
